// ===== hw/rtl/rvd_pkg.sv =====
package rvd_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  typedef enum logic [2:0] {
    FMT_U = 3'd0,
    FMT_J = 3'd1,
    FMT_I = 3'd2,
    FMT_S = 3'd3,
    FMT_B = 3'd4,
    FMT_R = 3'd5,
    FMT_X = 3'd6
  } fmt_t;

  typedef enum logic [5:0] {
    MN_LUI    = 6'd0,
    MN_AUIPC  = 6'd1,
    MN_JAL    = 6'd2,
    MN_JALR   = 6'd3,
    MN_BEQ    = 6'd4,
    MN_BNE    = 6'd5,
    MN_BLT    = 6'd6,
    MN_BGE    = 6'd7,
    MN_BLTU   = 6'd8,
    MN_BGEU   = 6'd9,
    MN_LB     = 6'd10,
    MN_LH     = 6'd11,
    MN_LW     = 6'd12,
    MN_LBU    = 6'd13,
    MN_LHU    = 6'd14,
    MN_SB     = 6'd15,
    MN_SH     = 6'd16,
    MN_SW     = 6'd17,
    MN_ADDI   = 6'd18,
    MN_SLTI   = 6'd19,
    MN_SLTIU  = 6'd20,
    MN_XORI   = 6'd21,
    MN_ORI    = 6'd22,
    MN_ANDI   = 6'd23,
    MN_SLLI   = 6'd24,
    MN_SRLI   = 6'd25,
    MN_SRAI   = 6'd26,
    MN_ADD    = 6'd27,
    MN_SUB    = 6'd28,
    MN_SLL    = 6'd29,
    MN_SLT    = 6'd30,
    MN_SLTU   = 6'd31,
    MN_XOR    = 6'd32,
    MN_SRL    = 6'd33,
    MN_SRA    = 6'd34,
    MN_OR     = 6'd35,
    MN_AND    = 6'd36,
    MN_ECALL  = 6'd37,
    MN_EBREAK = 6'd38,
    MN_MUL    = 6'd39,
    MN_MULH   = 6'd40,
    MN_MULHSU = 6'd41,
    MN_MULHU  = 6'd42,
    MN_DIV    = 6'd43,
    MN_DIVU   = 6'd44,
    MN_REM    = 6'd45,
    MN_REMU   = 6'd46,
    MN_BAD    = 6'd47
  } mnem_t;

  // decoded fields handed from the decoder to the result stage
  typedef struct packed {
    mnem_t       mnemonic;
    fmt_t        format;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic        tgt_en;
  } dec_t;

  function automatic mnem_t branch_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_BEQ;
      3'd1: m = MN_BNE;
      3'd4: m = MN_BLT;
      3'd5: m = MN_BGE;
      3'd6: m = MN_BLTU;
      3'd7: m = MN_BGEU;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

  function automatic mnem_t load_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_LB;
      3'd1: m = MN_LH;
      3'd2: m = MN_LW;
      3'd4: m = MN_LBU;
      3'd5: m = MN_LHU;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

  function automatic mnem_t store_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_SB;
      3'd1: m = MN_SH;
      3'd2: m = MN_SW;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

  function automatic mnem_t opimm_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_ADDI;
      3'd2: m = MN_SLTI;
      3'd3: m = MN_SLTIU;
      3'd4: m = MN_XORI;
      3'd6: m = MN_ORI;
      3'd7: m = MN_ANDI;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

  function automatic mnem_t reg_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_ADD;
      3'd1: m = MN_SLL;
      3'd2: m = MN_SLT;
      3'd3: m = MN_SLTU;
      3'd4: m = MN_XOR;
      3'd5: m = MN_SRL;
      3'd6: m = MN_OR;
      3'd7: m = MN_AND;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

  function automatic mnem_t muldiv_code(input logic [2:0] f3);
    mnem_t m;
    case (f3)
      3'd0: m = MN_MUL;
      3'd1: m = MN_MULH;
      3'd2: m = MN_MULHSU;
      3'd3: m = MN_MULHU;
      3'd4: m = MN_DIV;
      3'd5: m = MN_DIVU;
      3'd6: m = MN_REM;
      3'd7: m = MN_REMU;
      default: m = MN_BAD;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/rvd_decode.sv =====
module rvd_decode (
  input  logic [31:0]   word,
  output rvd_pkg::dec_t dec
);
  import rvd_pkg::*;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] shamt;
  dec_t        raw;

  assign op  = word[6:0];
  assign rd  = word[11:7];
  assign f3  = word[14:12];
  assign rs1 = word[19:15];
  assign rs2 = word[24:20];
  assign f7  = word[31:25];

  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign imm_u = {word[31:12], 12'd0};
  assign shamt = {27'd0, rs2};

  always_comb begin
    raw = '{mnemonic: MN_BAD, format: FMT_X, rd: 5'd0, rs1: 5'd0, rs2: 5'd0,
            imm: 32'd0, tgt_en: 1'b0};
    case (op)
      OP_LUI, OP_AUIPC: begin
        raw.mnemonic = (op == OP_LUI) ? MN_LUI : MN_AUIPC;
        raw.format   = FMT_U;
        raw.rd       = rd;
        raw.imm      = imm_u;
      end
      OP_JAL: begin
        raw.mnemonic = MN_JAL;
        raw.format   = FMT_J;
        raw.rd       = rd;
        raw.imm      = imm_j;
        raw.tgt_en   = 1'b1;
      end
      OP_JALR: begin
        raw.mnemonic = (f3 == 3'd0) ? MN_JALR : MN_BAD;
        raw.format   = FMT_I;
        raw.rd       = rd;
        raw.rs1      = rs1;
        raw.imm      = imm_i;
      end
      OP_BRANCH: begin
        raw.mnemonic = branch_code(f3);
        raw.format   = FMT_B;
        raw.rs1      = rs1;
        raw.rs2      = rs2;
        raw.imm      = imm_b;
        raw.tgt_en   = 1'b1;
      end
      OP_LOAD: begin
        raw.mnemonic = load_code(f3);
        raw.format   = FMT_I;
        raw.rd       = rd;
        raw.rs1      = rs1;
        raw.imm      = imm_i;
      end
      OP_STORE: begin
        raw.mnemonic = store_code(f3);
        raw.format   = FMT_S;
        raw.rs1      = rs1;
        raw.rs2      = rs2;
        raw.imm      = imm_s;
      end
      OP_IMM: begin
        raw.format = FMT_I;
        raw.rd     = rd;
        raw.rs1    = rs1;
        if (f3 == 3'd1) begin
          raw.mnemonic = (f7 == F7_BASE) ? MN_SLLI : MN_BAD;
          raw.imm      = shamt;
        end else if (f3 == 3'd5) begin
          if (f7 == F7_BASE) begin
            raw.mnemonic = MN_SRLI;
          end else if (f7 == F7_ALT) begin
            raw.mnemonic = MN_SRAI;
          end
          raw.imm = shamt;
        end else begin
          raw.mnemonic = opimm_code(f3);
          raw.imm      = imm_i;
        end
      end
      OP_REG: begin
        raw.format = FMT_R;
        raw.rd     = rd;
        raw.rs1    = rs1;
        raw.rs2    = rs2;
        if (f7 == F7_BASE) begin
          raw.mnemonic = reg_code(f3);
        end else if (f7 == F7_MULDIV) begin
          raw.mnemonic = muldiv_code(f3);
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          raw.mnemonic = MN_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          raw.mnemonic = MN_SRA;
        end
      end
      OP_SYSTEM: begin
        // only the exact ecall / ebreak words
        if (f3 == 3'd0 && rd == 5'd0 && rs1 == 5'd0 && word[31:21] == 11'd0) begin
          raw.mnemonic = word[20] ? MN_EBREAK : MN_ECALL;
          raw.format   = FMT_I;
          raw.imm      = {31'd0, word[20]};
        end
      end
      default: begin
        raw.mnemonic = MN_BAD;
      end
    endcase
  end

  // an unrecognized word clears every field
  always_comb begin
    dec = raw;
    if (raw.mnemonic == MN_BAD) begin
      dec = '{mnemonic: MN_BAD, format: FMT_X, rd: 5'd0, rs1: 5'd0, rs2: 5'd0,
              imm: 32'd0, tgt_en: 1'b0};
    end
  end

endmodule

// ===== hw/rtl/rv32im_instruction_decoder.sv =====
// an accepted request is captured in the input register, and its decode
// and target are captured in the result register as out_valid rises
// throughput: one request per cycle; busy is always low
// an input register feeds the decoder, a result register holds its output
// and the pc + immediate target add
// reset clears only the valid flags; the receiver cannot stall
module rv32im_instruction_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_instr_word,
  input  logic [31:0]        in_pc,
  output logic               out_valid,
  output logic [5:0]         out_mnemonic,
  output logic [2:0]         out_format,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src1_reg,
  output logic [4:0]         out_src2_reg,
  output logic signed [31:0] out_immediate,
  output logic [31:0]        out_target_addr
);
  import rvd_pkg::*;

  logic        in_valid_r;
  logic [31:0] word_r;
  logic [31:0] pc_r;
  dec_t        dec;
  logic [31:0] tgt_nxt;
  logic        out_valid_r;
  dec_t        dec_r;
  logic [31:0] tgt_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= in_instr_word;
      pc_r   <= in_pc;
    end
  end

  rvd_decode u_decode (
    .word (word_r),
    .dec  (dec)
  );

  assign tgt_nxt = dec.tgt_en ? (pc_r + dec.imm) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      dec_r <= dec;
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mnemonic    = dec_r.mnemonic;
  assign out_format      = dec_r.format;
  assign out_dest_reg    = dec_r.rd;
  assign out_src1_reg    = dec_r.rs1;
  assign out_src2_reg    = dec_r.rs2;
  assign out_immediate   = $signed(dec_r.imm);
  assign out_target_addr = tgt_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without a request two cycles earlier");

  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format == FMT_X |->
      out_mnemonic == MN_BAD && out_dest_reg == 5'd0 && out_src1_reg == 5'd0 &&
      out_src2_reg == 5'd0 && out_immediate == 32'sd0 && out_target_addr == 32'd0)
    else $error("unrecognized word with nonzero fields");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format != FMT_B && out_mnemonic != MN_JAL |->
      out_target_addr == 32'd0)
    else $error("target set outside branch and jal");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rvd_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [31:0] pc;
    bit          drain;
  } decode_req_t;

  typedef struct {
    logic [31:0] word;
    logic [31:0] pc;
    mnem_t       mnemonic;
    fmt_t        format;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] target;
  } insn_fields_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        in_instr_word = '0;
  logic [31:0]        in_pc = '0;
  logic               out_valid;
  logic [5:0]         out_mnemonic;
  logic [2:0]         out_format;
  logic [4:0]         out_dest_reg;
  logic [4:0]         out_src1_reg;
  logic [4:0]         out_src2_reg;
  logic signed [31:0] out_immediate;
  logic [31:0]        out_target_addr;

  decode_req_t  pend_q[$];
  insn_fields_t exp_decodes[$];
  decode_req_t  next_req;
  insn_fields_t want;
  int           burst_left = 1;
  int           gap_left = 0;
  int           fail_cnt = 0;

  rv32im_instruction_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_instr_word  (in_instr_word),
    .in_pc          (in_pc),
    .out_valid      (out_valid),
    .out_mnemonic   (out_mnemonic),
    .out_format     (out_format),
    .out_dest_reg   (out_dest_reg),
    .out_src1_reg   (out_src1_reg),
    .out_src2_reg   (out_src2_reg),
    .out_immediate  (out_immediate),
    .out_target_addr(out_target_addr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic insn_fields_t decode_insn(input logic [31:0] w, input logic [31:0] pc);
    insn_fields_t r;
    logic [2:0]   f3;
    logic [6:0]   f7;
    f3 = w[14:12];
    f7 = w[31:25];
    r.word = w;
    r.pc = pc;
    r.mnemonic = MN_BAD;
    r.format = FMT_X;
    r.rd = '0;
    r.rs1 = '0;
    r.rs2 = '0;
    r.imm = '0;
    r.target = '0;
    case (w[6:0])
      OP_LUI, OP_AUIPC: begin
        r.mnemonic = (w[6:0] == OP_LUI) ? MN_LUI : MN_AUIPC;
        r.format = FMT_U;
        r.rd = w[11:7];
        r.imm = {w[31:12], 12'b0};
      end
      OP_JAL: begin
        r.mnemonic = MN_JAL;
        r.format = FMT_J;
        r.rd = w[11:7];
        r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.target = pc + r.imm;
      end
      OP_JALR: begin
        if (f3 == 3'd0) r.mnemonic = MN_JALR;
        r.format = FMT_I;
        r.rd = w[11:7];
        r.rs1 = w[19:15];
        r.imm = {{20{w[31]}}, w[31:20]};
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: r.mnemonic = MN_BEQ;
          3'd1: r.mnemonic = MN_BNE;
          3'd4: r.mnemonic = MN_BLT;
          3'd5: r.mnemonic = MN_BGE;
          3'd6: r.mnemonic = MN_BLTU;
          3'd7: r.mnemonic = MN_BGEU;
          default: r.mnemonic = MN_BAD;
        endcase
        r.format = FMT_B;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        r.target = pc + r.imm;
      end
      OP_LOAD: begin
        case (f3)
          3'd0: r.mnemonic = MN_LB;
          3'd1: r.mnemonic = MN_LH;
          3'd2: r.mnemonic = MN_LW;
          3'd4: r.mnemonic = MN_LBU;
          3'd5: r.mnemonic = MN_LHU;
          default: r.mnemonic = MN_BAD;
        endcase
        r.format = FMT_I;
        r.rd = w[11:7];
        r.rs1 = w[19:15];
        r.imm = {{20{w[31]}}, w[31:20]};
      end
      OP_STORE: begin
        case (f3)
          3'd0: r.mnemonic = MN_SB;
          3'd1: r.mnemonic = MN_SH;
          3'd2: r.mnemonic = MN_SW;
          default: r.mnemonic = MN_BAD;
        endcase
        r.format = FMT_S;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OP_IMM: begin
        r.format = FMT_I;
        r.rd = w[11:7];
        r.rs1 = w[19:15];
        case (f3)
          3'd0: r.mnemonic = MN_ADDI;
          3'd1: r.mnemonic = (f7 == F7_BASE) ? MN_SLLI : MN_BAD;
          3'd2: r.mnemonic = MN_SLTI;
          3'd3: r.mnemonic = MN_SLTIU;
          3'd4: r.mnemonic = MN_XORI;
          3'd5: begin
            if (f7 == F7_BASE) r.mnemonic = MN_SRLI;
            else if (f7 == F7_ALT) r.mnemonic = MN_SRAI;
          end
          3'd6: r.mnemonic = MN_ORI;
          default: r.mnemonic = MN_ANDI;
        endcase
        // shifts carry the shift amount, the rest a sign-extended immediate
        if (f3 == 3'd1 || f3 == 3'd5) r.imm = {27'b0, w[24:20]};
        else r.imm = {{20{w[31]}}, w[31:20]};
      end
      OP_REG: begin
        r.format = FMT_R;
        r.rd = w[11:7];
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: r.mnemonic = MN_ADD;
            3'd1: r.mnemonic = MN_SLL;
            3'd2: r.mnemonic = MN_SLT;
            3'd3: r.mnemonic = MN_SLTU;
            3'd4: r.mnemonic = MN_XOR;
            3'd5: r.mnemonic = MN_SRL;
            3'd6: r.mnemonic = MN_OR;
            default: r.mnemonic = MN_AND;
          endcase
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: r.mnemonic = MN_MUL;
            3'd1: r.mnemonic = MN_MULH;
            3'd2: r.mnemonic = MN_MULHSU;
            3'd3: r.mnemonic = MN_MULHU;
            3'd4: r.mnemonic = MN_DIV;
            3'd5: r.mnemonic = MN_DIVU;
            3'd6: r.mnemonic = MN_REM;
            default: r.mnemonic = MN_REMU;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          r.mnemonic = MN_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          r.mnemonic = MN_SRA;
        end
      end
      OP_SYSTEM: begin
        if (w[19:7] == 13'b0 && w[31:21] == 11'b0) begin
          r.mnemonic = w[20] ? MN_EBREAK : MN_ECALL;
          r.format = FMT_I;
          r.imm = {31'b0, w[20]};
        end
      end
      default: ;
    endcase
    // any unrecognized word reports all fields cleared
    if (r.mnemonic == MN_BAD) begin
      r.format = FMT_X;
      r.rd = '0;
      r.rs1 = '0;
      r.rs2 = '0;
      r.imm = '0;
      r.target = '0;
    end
    return r;
  endfunction

  function automatic logic [31:0] make_insn();
    logic [31:0] w;
    logic [6:0]  op;
    int unsigned pick;
    int unsigned sel;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10) return w;
    case ($urandom_range(0, 9))
      0: op = OP_LUI;
      1: op = OP_AUIPC;
      2: op = OP_JAL;
      3: op = OP_JALR;
      4: op = OP_BRANCH;
      5: op = OP_LOAD;
      6: op = OP_STORE;
      7: op = OP_IMM;
      8: op = OP_REG;
      default: op = OP_SYSTEM;
    endcase
    w[6:0] = op;
    // valid opcode with random funct fields
    if (pick < 22) return w;
    case (op)
      OP_JALR: w[14:12] = 3'd0;
      OP_BRANCH: begin
        sel = $urandom_range(0, 5);
        w[14:12] = (sel < 2) ? sel[2:0] : sel[2:0] + 3'd2;
      end
      OP_LOAD: begin
        sel = $urandom_range(0, 4);
        w[14:12] = (sel < 3) ? sel[2:0] : sel[2:0] + 3'd1;
      end
      OP_STORE: begin
        sel = $urandom_range(0, 2);
        w[14:12] = sel[2:0];
      end
      OP_IMM: begin
        if (w[13:12] == 2'b01)
          w[31:25] = (w[14] && $urandom_range(0, 1) == 1) ? F7_ALT : F7_BASE;
      end
      OP_REG: begin
        case ($urandom_range(0, 2))
          0: w[31:25] = F7_BASE;
          1: w[31:25] = F7_MULDIV;
          default: begin
            w[31:25] = F7_ALT;
            w[14:12] = ($urandom_range(0, 1) == 1) ? 3'd5 : 3'd0;
          end
        endcase
      end
      OP_SYSTEM: begin
        w[19:7] = 13'b0;
        w[31:21] = 11'b0;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_req(input logic [31:0] word, input logic [31:0] pc, input bit drain);
    decode_req_t r;
    r.word = word;
    r.pc = pc;
    r.drain = drain;
    pend_q.insert(pend_q.size(), r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (start && !busy)
        exp_decodes.insert(exp_decodes.size(), decode_insn(in_instr_word, in_pc));
      if (start && busy) begin
        // request not taken yet, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pend_q.size() != 0 && !(pend_q[0].drain && exp_decodes.size() != 0)) begin
        next_req = pend_q.pop_front();
        in_instr_word <= next_req.word;
        in_pc <= next_req.pc;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (exp_decodes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected decode result: mnem %0d fmt %0d", out_mnemonic, out_format);
      end else begin
        want = exp_decodes.pop_front();
        if (out_mnemonic !== want.mnemonic || out_format !== want.format ||
            out_dest_reg !== want.rd || out_src1_reg !== want.rs1 ||
            out_src2_reg !== want.rs2 || out_immediate !== want.imm ||
            out_target_addr !== want.target) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("decode mismatch word %h pc %h", want.word, want.pc);
            $display("  expected mnem %0d fmt %0d rd %0d rs1 %0d rs2 %0d imm %h tgt %h",
                     want.mnemonic, want.format, want.rd, want.rs1, want.rs2,
                     want.imm, want.target);
            $display("  actual   mnem %0d fmt %0d rd %0d rs1 %0d rs2 %0d imm %h tgt %h",
                     out_mnemonic, out_format, out_dest_reg, out_src1_reg,
                     out_src2_reg, out_immediate, out_target_addr);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] pc_val;
    // directed requests
    add_req(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req({20'hFFFFF, 5'd31, OP_LUI}, 32'h0000_1000, 1'b0);
    add_req({20'h80000, 5'd1, OP_AUIPC}, 32'hFFFF_FFFF, 1'b0);
    add_req({1'b1, 10'h000, 1'b0, 8'h00, 5'd0, OP_JAL}, 32'h0000_0000, 1'b0);
    add_req({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OP_JAL}, 32'hFFFF_FF00, 1'b0);
    add_req({12'hFFF, 5'd31, 3'd0, 5'd5, OP_JALR}, 32'h1234_5678, 1'b0);
    add_req({12'h7FF, 5'd1, 3'd1, 5'd2, OP_JALR}, 32'h0000_0040, 1'b0);
    add_req({7'h40, 5'd31, 5'd31, 3'd0, 5'h00, OP_BRANCH}, 32'h0000_0800, 1'b0);
    add_req({7'h3F, 5'd1, 5'd2, 3'd7, 5'h1F, OP_BRANCH}, 32'hFFFF_F800, 1'b0);
    add_req({7'h00, 5'd3, 5'd4, 3'd2, 5'd8, OP_BRANCH}, 32'h0000_0100, 1'b0);
    add_req({12'h800, 5'd7, 3'd2, 5'd9, OP_LOAD}, 32'h0000_0004, 1'b0);
    add_req({12'h000, 5'd7, 3'd3, 5'd9, OP_LOAD}, 32'h0000_0008, 1'b0);
    add_req({7'h7F, 5'd31, 5'd1, 3'd2, 5'h1F, OP_STORE}, 32'h0000_000C, 1'b0);
    add_req({7'h3F, 5'd2, 5'd3, 3'd0, 5'h00, OP_STORE}, 32'h0000_0010, 1'b0);
    add_req({7'h01, 5'd2, 5'd3, 3'd3, 5'h04, OP_STORE}, 32'h0000_0014, 1'b0);
    add_req({12'h7FF, 5'd1, 3'd0, 5'd1, OP_IMM}, 32'h0000_0018, 1'b0);
    add_req({F7_BASE, 5'd31, 5'd2, 3'd1, 5'd3, OP_IMM}, 32'h0000_001C, 1'b0);
    add_req({F7_ALT, 5'd31, 5'd2, 3'd5, 5'd3, OP_IMM}, 32'h0000_0020, 1'b0);
    add_req({F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, OP_IMM}, 32'h0000_0024, 1'b0);
    add_req({F7_ALT, 5'd31, 5'd30, 3'd5, 5'd29, OP_REG}, 32'h0000_0028, 1'b0);
    add_req({F7_BASE, 5'd0, 5'd31, 3'd5, 5'd1, OP_REG}, 32'h0000_002C, 1'b0);
    add_req({F7_ALT, 5'd4, 5'd5, 3'd1, 5'd6, OP_REG}, 32'h0000_0030, 1'b0);
    add_req({F7_MULDIV, 5'd7, 5'd8, 3'd7, 5'd9, OP_REG}, 32'h0000_0034, 1'b0);
    add_req(32'h0000_0073, 32'h0000_0038, 1'b0);
    add_req(32'h0010_0073, 32'h0000_003C, 1'b0);
    add_req(32'h0000_00F3, 32'h0000_0040, 1'b0);
    add_req(32'h0020_0073, 32'h0000_0044, 1'b0);
    add_req(32'h0000_000F, 32'h0000_0048, 1'b0);
    // random requests, mostly well-formed
    for (int i = 0; i < 550; i++) begin
      case ($urandom_range(0, 9))
        0: pc_val = 32'h0000_0000;
        1: pc_val = 32'hFFFF_FFFC;
        2: pc_val = 32'h7FFF_FFF0;
        default: pc_val = $urandom;
      endcase
      add_req(make_insn(), pc_val, i == 0 || i == 300 || $urandom_range(0, 99) == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || start || exp_decodes.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (exp_decodes.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
